[rtl/isort_pkg.sv]
// ----------------------------------------------------------------------------
// isort_pkg: shared types and constants of the integer sort engine
// Data width, default capacity, cell control bundle and sequencer states.
// ----------------------------------------------------------------------------
package isort_pkg;

	// width of one stored integer
	localparam int DATA_W = 32;

	// default number of cells in the sorting chain
	localparam int MAX_VALUES_DEF = 64;

	// control sent from the sequencer to every cell
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

	// sequencer states
	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

endpackage

[rtl/integer_sort_engine_core.sv]
// ----------------------------------------------------------------------------
// integer_sort_engine_core: ascending sort of a set of signed integers
// A chain of MAX_VALUES cells keeps the set sorted as it loads, then drains.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid / in_stall, value, last_value): one integer per
//    transfer; the transfer with last_value set closes the set.
//  - each value that finds a free cell is inserted into the sorted chain in
//    the cycle it transfers, so loading runs at one value per cycle.
//  - after the closing transfer the chain shifts out toward the output
//    register, one value per cycle while the receiver does not stall; the
//    sequencer first enters its drain state, then the smallest value moves
//    into the output register as the first result.
//  - in_stall is high while the set drains; the next set may start while
//    the final result still waits in the output register.
//  - output channel (out_valid / out_stall, sorted_value, last_result,
//    overflow): last_result marks the largest value, overflow marks every
//    result of a set that lost values beyond MAX_VALUES.
//  - an output stall freezes the drain; nothing is lost.
//  - reset empties the chain and clears the count and the drop flag.
// ----------------------------------------------------------------------------
module integer_sort_engine_core #(
	parameter int MAX_VALUES = isort_pkg::MAX_VALUES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [isort_pkg::DATA_W-1:0] value,
	input  logic                                last_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [isort_pkg::DATA_W-1:0] sorted_value,
	output logic                                last_result,
	output logic                                overflow
);
	import isort_pkg::*;

	localparam int CNT_W = $clog2(MAX_VALUES + 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             drop_q;
	logic             out_valid_q;
	logic             out_last_q;
	logic             out_ovf_q;
	logic signed [DATA_W-1:0] out_value_q;

	logic             in_xfer;
	logic             full;
	logic             load_out;
	logic             last_load;
	cell_ctl_t        ctl;

	logic [MAX_VALUES-1:0]    cell_valid;
	logic [MAX_VALUES-1:0]    cell_gt;
	logic signed [DATA_W-1:0] cell_value [MAX_VALUES];

	// handshake and control
	assign in_stall   = (state_q == ST_DRAIN);
	assign in_xfer    = in_valid && !in_stall;
	assign full       = (count_q == CNT_W'(MAX_VALUES));
	assign load_out   = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall);
	assign last_load  = load_out && (count_q == CNT_W'(1));
	assign ctl.insert = in_xfer && !full;
	assign ctl.shift  = load_out;

	// sorting chain
	for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
		logic                     lv, lg, rv;
		logic signed [DATA_W-1:0] lval, rval;
		if (i == 0) begin : g_first
			assign lv   = 1'b0;
			assign lg   = 1'b0;
			assign lval = '0;
		end else begin : g_mid
			assign lv   = cell_valid[i-1];
			assign lg   = cell_gt[i-1];
			assign lval = cell_value[i-1];
		end
		if (i == MAX_VALUES - 1) begin : g_end
			assign rv   = 1'b0;
			assign rval = '0;
		end else begin : g_inner
			assign rv   = cell_valid[i+1];
			assign rval = cell_value[i+1];
		end
		isort_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_value   (value),
			.left_valid  (lv),
			.left_gt     (lg),
			.left_value  (lval),
			.right_valid (rv),
			.right_value (rval),
			.valid       (cell_valid[i]),
			.gt          (cell_gt[i]),
			.value_out   (cell_value[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_xfer && last_value) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (last_load) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// state, count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (load_out) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (in_xfer && full) begin
				drop_q <= 1'b1;
			end else if (last_load) begin
				drop_q <= 1'b0;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= cell_value[0];
			out_last_q  <= (count_q == CNT_W'(1));
			out_ovf_q   <= drop_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_value_q;
	assign last_result  = out_last_q;
	assign overflow     = out_ovf_q;

`ifndef NO_ASSERTIONS
	// occupied cells always match the count
	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("cell occupancy differs from count");

	// draining never runs on an empty chain
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (count_q != '0) && cell_valid[0])
		else $error("drain with empty chain");

	// the final result of a set ends the drain
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last_load |=> (state_q == ST_LOAD) && out_valid_q && out_last_q)
		else $error("final result did not end drain");

	// the first two cells of the chain stay in ascending order
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[1] |-> (cell_value[0] <= cell_value[1]))
		else $error("chain head out of order");
`endif

endmodule

[rtl/isort_cell.sv]
// ----------------------------------------------------------------------------
// isort_cell: one cell of the sorting chain
// Holds one value; on insert it keeps, takes the new value or takes the left
// neighbor's value so the chain stays ascending; on shift it takes the right.
// ----------------------------------------------------------------------------
module isort_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  isort_pkg::cell_ctl_t                ctl,
	input  logic signed [isort_pkg::DATA_W-1:0] new_value,
	input  logic                                left_valid,
	input  logic                                left_gt,
	input  logic signed [isort_pkg::DATA_W-1:0] left_value,
	input  logic                                right_valid,
	input  logic signed [isort_pkg::DATA_W-1:0] right_value,
	output logic                                valid,
	output logic                                gt,
	output logic signed [isort_pkg::DATA_W-1:0] value_out
);
	import isort_pkg::*;

	logic              valid_q;
	logic signed [DATA_W-1:0] value_q;

	// an empty cell counts as larger than any value
	assign gt        = !valid_q || (new_value < value_q);
	assign valid     = valid_q;
	assign value_out = value_q;

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= right_valid;
		end else if (ctl.insert && gt) begin
			valid_q <= valid_q | left_valid | !left_gt;
		end
	end

	// stored value
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= right_value;
		end else if (ctl.insert && gt) begin
			value_q <= left_gt ? left_value : new_value;
		end
	end

endmodule
